// ----- design/tmms_pkg.sv -----
package tmms_pkg;

  localparam int STEP_TABLE_DEPTH = 16;
  localparam int ROW_W = 32;
  localparam int TIME_W = 14;
  localparam int DRV_W = 9;
  localparam logic [TIME_W-1:0] TIME_MAX = 14'd16383;
  localparam logic [15:0] LIFE_MIN = 16'd1000;
  localparam logic [15:0] LIFE_MAX = 16'd10000;
  // base + step index never exceeds this width
  localparam int BASE_ADDR_W = 5;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

  function automatic logic [ROW_W-1:0] pack_row(logic signed [8:0] v, logic signed [8:0] w,
                                                logic [13:0] d);
    return {v, w, d};
  endfunction

  // row = speed[31:23], turn[22:14], duration[13:0]
  function automatic logic [ROW_W-1:0] step_row(int idx);
    logic [ROW_W-1:0] row;
    unique case (idx)
      0:       row = pack_row(9'sd150, 9'sd75, 14'd2000);
      1:       row = pack_row(9'sd150, -9'sd75, 14'd2000);
      2:       row = pack_row(9'sd150, 9'sd75, 14'd2000);
      3:       row = pack_row(9'sd150, -9'sd75, 14'd2000);
      4:       row = pack_row(9'sd0, 9'sd0, 14'd500);
      5:       row = pack_row(9'sd0, 9'sd250, 14'd1800);
      6:       row = pack_row(9'sd0, 9'sd0, 14'd500);
      7:       row = pack_row(9'sd100, 9'sd150, 14'd300);
      8:       row = pack_row(9'sd100, -9'sd150, 14'd300);
      9:       row = pack_row(9'sd100, 9'sd150, 14'd300);
      10:      row = pack_row(9'sd100, -9'sd150, 14'd300);
      11:      row = pack_row(9'sd0, 9'sd0, 14'd500);
      12:      row = pack_row(9'sd200, 9'sd0, 14'd2000);
      13:      row = pack_row(9'sd0, 9'sd0, 14'd500);
      default: row = '0;
    endcase
    return row;
  endfunction

  function automatic logic [3:0] macro_base(logic [1:0] m);
    logic [3:0] b;
    unique case (m)
      2'd0: b = 4'd0;
      2'd1: b = 4'd5;
      2'd2: b = 4'd7;
      2'd3: b = 4'd12;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] macro_len(logic [1:0] m);
    logic [2:0] n;
    unique case (m)
      2'd0: n = 3'd5;
      2'd1: n = 3'd2;
      2'd2: n = 3'd5;
      2'd3: n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- design/tmms_step_rom.sv -----
module tmms_step_rom #(
  parameter int DEPTH = tmms_pkg::STEP_TABLE_DEPTH,
  parameter int AW = $clog2(DEPTH) + 1
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [tmms_pkg::ROW_W-1:0]   rd_data
);

  localparam int IW = $clog2(DEPTH);

  logic [tmms_pkg::ROW_W-1:0] mem [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rows
    assign mem[i] = tmms_pkg::step_row(i);
  end

  // rows past the table depth read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_addr < AW'(DEPTH)) begin
        rd_data <= mem[rd_addr[IW-1:0]];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ----- design/timed_motion_macro_sequencer.sv -----
// Timed motion macro sequencer.
// Input channel (in_valid / in_stall): one request per cycle, opcode tick (1 ms),
// start macro or cancel. Start carries macro number, intensity and lifetime.
// Result channel (out_valid / out_stall): exactly one result per request, in order,
// carrying the left/right drive command, drive_valid, running and status.
// Throughput: one request per cycle sustained while out_stall is low. Each
// request passes a two-stage pipeline: step table read, then update/mix into
// the output register.
// The step table is a ROM with a registered read port; the read address for a
// request is formed from the state forwarded from the request ahead of it, so
// consecutive ticks need no bubble.
// Reset (rst_n low, synchronous) clears the pipeline and the macro state; the
// block is idle with no macro running and takes requests on the next cycle.
// When the receiver stalls, the output register holds its result; one more
// request may sit in the read stage, after which in_stall rises until the
// result is taken.
module timed_motion_macro_sequencer #(
  parameter int STEP_TABLE_DEPTH = tmms_pkg::STEP_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [2:0]        in_macro_number,
  input  logic [7:0]        in_intensity,
  input  logic [15:0]       in_lifetime_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [8:0] out_left_drive,
  output logic signed [8:0] out_right_drive,
  output logic              out_drive_valid,
  output logic              out_running,
  output logic [1:0]        out_status_code
);

  localparam int AW = $clog2(STEP_TABLE_DEPTH) + 1;
  localparam int TW = tmms_pkg::TIME_W;
  localparam int BW = tmms_pkg::BASE_ADDR_W;

  // read stage
  logic                       s1_v_r;
  logic [1:0]                 s1_op_r;
  logic [2:0]                 s1_mac_r;
  logic [7:0]                 s1_inten_r;
  logic [15:0]                s1_life_r;
  logic [tmms_pkg::ROW_W-1:0] rom_q;

  // macro state
  logic              active_r, active_nxt;
  logic [1:0]        cur_r, cur_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [TW-1:0]     st_r, st_nxt;
  logic [TW-1:0]     tt_r, tt_nxt;
  logic [TW-1:0]     life_r, life_nxt;
  logic [TW-1:0]     len_r, len_nxt;
  logic signed [8:0] spd_r, spd_nxt;
  logic signed [8:0] trn_r, trn_nxt;

  // output register
  logic              out_valid_r;
  logic signed [8:0] out_left_r, left_nxt;
  logic signed [8:0] out_right_r, right_nxt;
  logic              out_drv_r, drv_nxt;
  logic              out_run_r;
  logic [1:0]        out_status_r;
  tmms_pkg::status_t status_nxt;

  logic          adv;
  logic          in_acc;
  logic [BW-1:0] start_addr, tick_addr;
  logic [AW-1:0] rd_addr;
  logic [2:0]    pos_inc;

  logic [TW-1:0]     st1, tt1;
  logic [2:0]        pos1;
  logic signed [8:0] row_v, row_w, mix_v, mix_w;
  logic signed [9:0] sum_l, sum_r;

  assign adv      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // speed * intensity / 255, truncated toward zero
  function automatic logic signed [8:0] scale_255(logic signed [8:0] v, logic [7:0] k);
    logic [8:0]  mag;
    logic [16:0] m;
    logic [16:0] q;
    mag = v[8] ? 9'(-v) : 9'(v);
    m   = mag * k;
    q   = (m + (m >> 8) + 17'd1) >> 8;
    return v[8] ? -$signed(9'(q)) : $signed(9'(q));
  endfunction

  function automatic logic signed [8:0] clamp255(logic signed [9:0] x);
    logic signed [8:0] r;
    if (x > 10'sd255) begin
      r = 9'sd255;
    end else if (x < -10'sd255) begin
      r = -9'sd255;
    end else begin
      r = x[8:0];
    end
    return r;
  endfunction

  assign row_v = $signed(rom_q[31:23]);
  assign row_w = $signed(rom_q[22:14]);
  assign st1   = (st_r == tmms_pkg::TIME_MAX) ? st_r : st_r + 1'b1;
  assign tt1   = (tt_r == tmms_pkg::TIME_MAX) ? tt_r : tt_r + 1'b1;
  assign pos1  = pos_r + 3'd1;
  assign sum_l = 10'(mix_v) - 10'(mix_w);
  assign sum_r = 10'(mix_v) + 10'(mix_w);

  always_comb begin
    active_nxt = active_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    st_nxt     = st_r;
    tt_nxt     = tt_r;
    life_nxt   = life_r;
    len_nxt    = len_r;
    spd_nxt    = spd_r;
    trn_nxt    = trn_r;
    status_nxt = tmms_pkg::ST_OK;
    drv_nxt    = 1'b0;
    mix_v      = spd_r;
    mix_w      = trn_r;
    if (adv) begin
      unique case (s1_op_r)
        tmms_pkg::OP_START: begin
          if (s1_mac_r[2]) begin
            status_nxt = tmms_pkg::ST_REJECT;
          end else begin
            cur_nxt    = s1_mac_r[1:0];
            pos_nxt    = 3'd0;
            st_nxt     = '0;
            tt_nxt     = '0;
            active_nxt = 1'b1;
            if (s1_life_r < tmms_pkg::LIFE_MIN) begin
              life_nxt = TW'(tmms_pkg::LIFE_MIN);
            end else if (s1_life_r > tmms_pkg::LIFE_MAX) begin
              life_nxt = TW'(tmms_pkg::LIFE_MAX);
            end else begin
              life_nxt = s1_life_r[TW-1:0];
            end
            len_nxt = rom_q[TW-1:0];
            spd_nxt = scale_255(row_v, s1_inten_r);
            trn_nxt = scale_255(row_w, s1_inten_r);
          end
        end
        tmms_pkg::OP_CANCEL: begin
          active_nxt = 1'b0;
        end
        tmms_pkg::OP_TICK: begin
          if (active_r) begin
            st_nxt  = st1;
            tt_nxt  = tt1;
            drv_nxt = 1'b1;
            if (tt1 >= life_r) begin
              active_nxt = 1'b0;
              status_nxt = tmms_pkg::ST_EXPIRED;
              drv_nxt    = 1'b0;
            end else if (st1 >= len_r) begin
              pos_nxt = pos1;
              st_nxt  = '0;
              if (pos1 >= tmms_pkg::macro_len(cur_r)) begin
                active_nxt = 1'b0;
                status_nxt = tmms_pkg::ST_DONE;
                drv_nxt    = 1'b0;
              end else begin
                len_nxt = rom_q[TW-1:0];
                spd_nxt = row_v;
                trn_nxt = row_w;
                mix_v   = row_v;
                mix_w   = row_w;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (drv_nxt) begin
      left_nxt  = clamp255(sum_l);
      right_nxt = clamp255(sum_r);
    end else begin
      left_nxt  = '0;
      right_nxt = '0;
    end
  end

  // read address uses the state as it stands after the request ahead
  assign pos_inc    = pos_nxt + 3'd1;
  assign start_addr = BW'(tmms_pkg::macro_base(in_macro_number[1:0]));
  assign tick_addr  = BW'(tmms_pkg::macro_base(cur_nxt)) + BW'(pos_inc);
  assign rd_addr    = (in_opcode == tmms_pkg::OP_START) ? AW'(start_addr) : AW'(tick_addr);

  tmms_step_rom #(
    .DEPTH (STEP_TABLE_DEPTH),
    .AW    (AW)
  ) u_rom (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      cur_r       <= '0;
      pos_r       <= '0;
      st_r        <= '0;
      tt_r        <= '0;
      life_r      <= '0;
      len_r       <= '0;
      spd_r       <= '0;
      trn_r       <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      active_r <= active_nxt;
      cur_r    <= cur_nxt;
      pos_r    <= pos_nxt;
      st_r     <= st_nxt;
      tt_r     <= tt_nxt;
      life_r   <= life_nxt;
      len_r    <= len_nxt;
      spd_r    <= spd_nxt;
      trn_r    <= trn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_opcode;
      s1_mac_r   <= in_macro_number;
      s1_inten_r <= in_intensity;
      s1_life_r  <= in_lifetime_ms;
    end
    if (adv) begin
      out_left_r   <= left_nxt;
      out_right_r  <= right_nxt;
      out_drv_r    <= drv_nxt;
      out_run_r    <= active_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;
  assign out_drive_valid = out_drv_r;
  assign out_running     = out_run_r;
  assign out_status_code = out_status_r;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_drive_keeps_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drive_valid) |-> out_running)
    else $error("drive command on a stopped macro");

  a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_drive_valid) |-> (out_left_drive == 9'sd0 && out_right_drive == 9'sd0))
    else $error("nonzero drive without command");

  a_status_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status_code != tmms_pkg::ST_OK) |-> !out_drive_valid)
    else $error("drive command with nonzero status");

  a_stop_clears_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status_code == tmms_pkg::ST_EXPIRED ||
                   out_status_code == tmms_pkg::ST_DONE)) |-> !out_running)
    else $error("macro still running after stop status");
`endif

endmodule
